FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the escaper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define HEB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("heb assertion failed");

// check a property on every clock edge, reset included
`define HEB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("heb assertion failed");

`endif

FILE: sv/heb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heb_pkg
// Types, character codes and entity tables of the bounded HTML escaper.
// ----------------------------------------------------------------------------
package heb_pkg;

    localparam int CAP_W      = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int IDX_W      = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;
    localparam logic             REG_DEST_CAPACITY = 1'b0;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    localparam logic [47:0] ENT_LT   = 48'("&lt;");
    localparam logic [47:0] ENT_GT   = 48'("&gt;");
    localparam logic [47:0] ENT_AMP  = 48'("&amp;");
    localparam logic [47:0] ENT_QUOT = 48'("&quot;");
    localparam logic [47:0] ENT_APOS = 48'("&#39;");

    typedef enum logic [2:0] {
        JOB_CHAR,
        JOB_LT,
        JOB_GT,
        JOB_AMP,
        JOB_QUOT,
        JOB_APOS,
        JOB_END_OK,
        JOB_END_ERR
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] ch;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_rd_t;

    function automatic logic [IDX_W-1:0] job_len(input job_kind_t kind);
        logic [IDX_W-1:0] len;
        unique case (kind)
            JOB_LT, JOB_GT:    len = 3'd4;
            JOB_AMP, JOB_APOS: len = 3'd5;
            JOB_QUOT:          len = 3'd6;
            default:           len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] job_byte(input job_kind_t kind, input logic [7:0] ch,
                                            input logic [IDX_W-1:0] idx);
        logic [47:0]      ent;
        logic [IDX_W-1:0] shift;
        logic [7:0]       b;
        shift = job_len(kind) - 3'd1 - idx;
        unique case (kind)
            JOB_LT:   ent = ENT_LT;
            JOB_GT:   ent = ENT_GT;
            JOB_AMP:  ent = ENT_AMP;
            JOB_QUOT: ent = ENT_QUOT;
            JOB_APOS: ent = ENT_APOS;
            default:  ent = '0;
        endcase
        unique case (kind)
            JOB_CHAR:                b = ch;
            JOB_END_OK, JOB_END_ERR: b = CH_NUL;
            default:                 b = 8'(ent >> {shift, 3'b000});
        endcase
        return b;
    endfunction

endpackage

FILE: sv/heb_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// heb_queue
// Short job queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module heb_queue import heb_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  q_wr_t wr,
    output logic  full,
    input  logic  pop,
    output q_rd_t rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign rd.valid = (count_reg != '0);
    assign rd.job   = entries_reg[rd_ptr_reg];
    assign do_pop   = pop && rd.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr.push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!wr.push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.push) begin
            entries_reg[wr_ptr_reg] <= wr.job;
        end
    end

    `HEB_ASSERT(a_no_push_full, aclk, aresetn, !(wr.push && full))
    `HEB_ASSERT(a_count_bound, aclk, aresetn, count_reg <= FULL_CNT)
    `HEB_ASSERT(a_pop_drains, aclk, aresetn,
        (do_pop && !wr.push) |=> count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: sv/heb_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// heb_front
// Accepts source words, tracks the output position against the capacity,
// and queues one job per word that yields output.
// ----------------------------------------------------------------------------
module heb_front import heb_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CAP_W-1:0] capacity,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_char_value,
    input  logic             q_full,
    output q_wr_t            wr
);

    localparam int CMP_W = ((POSITION_BITS > CAP_W) ? POSITION_BITS : CAP_W) + 1;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << POSITION_BITS;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     err_reg, err_next;
    logic [CMP_W-1:0]         cap_w, pos_w, ent_len;
    logic                     accept, at_full, fits;
    job_kind_t                kind;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cap_w = CMP_W'(capacity);
        if (cap_w == '0) begin
            cap_w = CMP_W'(1);
        end
        if (cap_w > LIMIT) begin
            cap_w = LIMIT;
        end
        pos_w = CMP_W'(pos_reg);
        unique case (s_char_value)
            CH_LT:   kind = JOB_LT;
            CH_GT:   kind = JOB_GT;
            CH_AMP:  kind = JOB_AMP;
            CH_QUOT: kind = JOB_QUOT;
            CH_APOS: kind = JOB_APOS;
            default: kind = JOB_CHAR;
        endcase
        ent_len = CMP_W'(job_len(kind));
        at_full = (pos_w >= cap_w - 1'b1);
        fits    = ((pos_w + ent_len) < cap_w);
    end

    always_comb begin
        wr.push     = 1'b0;
        wr.job.kind = kind;
        wr.job.ch   = s_char_value;
        pos_next    = pos_reg;
        err_next    = err_reg;
        if (accept) begin
            priority if (s_char_value == CH_NUL) begin
                wr.push     = !err_reg;
                wr.job.kind = JOB_END_OK;
                pos_next    = '0;
                err_next    = 1'b0;
            end else if (err_reg || at_full) begin
                wr.push = 1'b0;
            end else if (fits) begin
                wr.push  = 1'b1;
                pos_next = POSITION_BITS'(pos_w + ent_len);
            end else begin
                wr.push     = 1'b1;
                wr.job.kind = JOB_END_ERR;
                err_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    `HEB_ASSERT(a_err_silent, aclk, aresetn, err_reg |-> !wr.push)
    `HEB_ASSERT(a_end_clears, aclk, aresetn,
        (accept && s_char_value == CH_NUL) |=> (pos_reg == '0 && !err_reg))
    `HEB_ASSERT(a_err_sets, aclk, aresetn,
        (wr.push && wr.job.kind == JOB_END_ERR) |=> err_reg)

endmodule

FILE: sv/heb_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// heb_back
// Expands queued jobs into output words, one word per cycle while the
// receiver takes them, into the output register.
// ----------------------------------------------------------------------------
module heb_back import heb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  q_rd_t      rd,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_end_of_output,
    output logic       m_status
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             eoo_reg, eoo_next;
    logic             status_reg, status_next;
    logic [IDX_W-1:0] head_len;
    logic             load, last;

    assign head_len = job_len(rd.job.kind);
    assign load     = rd.valid && (!valid_reg || m_ready);
    assign last     = (idx_reg == head_len - 1'b1);
    assign pop      = load && last;

    always_comb begin
        idx_next    = idx_reg;
        valid_next  = valid_reg && !m_ready;
        char_next   = char_reg;
        eoo_next    = eoo_reg;
        status_next = status_reg;
        if (load) begin
            idx_next    = last ? '0 : idx_reg + 1'b1;
            valid_next  = 1'b1;
            char_next   = job_byte(rd.job.kind, rd.job.ch, idx_reg);
            eoo_next    = (rd.job.kind == JOB_END_OK) || (rd.job.kind == JOB_END_ERR);
            status_next = (rd.job.kind == JOB_END_ERR);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg   <= char_next;
        eoo_reg    <= eoo_next;
        status_reg <= status_next;
    end

    assign m_valid         = valid_reg;
    assign m_out_char      = char_reg;
    assign m_end_of_output = eoo_reg;
    assign m_status        = status_reg;

    `HEB_ASSERT(a_idx_holds_head, aclk, aresetn, (idx_reg != '0) |-> rd.valid)
    `HEB_ASSERT(a_idx_in_range, aclk, aresetn, rd.valid |-> (idx_reg < head_len))
    `HEB_ASSERT(a_status_on_end, aclk, aresetn, (valid_reg && status_reg) |-> eoo_reg)

endmodule

FILE: sv/html_escape_bounded_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_escape_bounded_core
// Bounded HTML entity escaper: source words in, escaped words out.
// Path: a taken source word goes into the job queue, then the output register.
// Rate: one source word per cycle while the queue is not full; an entity word
// holds the queue head for 4 to 6 output words, one per cycle while taken.
// Reset: synchronous, active low; capacity returns to 256, position to zero.
// ----------------------------------------------------------------------------
module html_escape_bounded_core import heb_pkg::*; #(
    parameter int POSITION_BITS = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_char,
    output logic                  m_end_of_output,
    output logic                  m_status
);

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             cfg_wr, q_full, pop;
    q_wr_t            wr;
    q_rd_t            rd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEST_CAPACITY);
    assign cap_next = cfg_wr ? pwdata[CAP_W-1:0] : cap_reg;
    assign prdata = (paddr[2] == REG_DEST_CAPACITY) ? APB_DATA_W'(cap_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    heb_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .capacity     (cap_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_value (s_char_value),
        .q_full       (q_full),
        .wr           (wr)
    );

    heb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .full    (q_full),
        .pop     (pop),
        .rd      (rd)
    );

    heb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rd              (rd),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_end_of_output (m_end_of_output),
        .m_status        (m_status)
    );

endmodule

FILE: verif/tb_html_escape_bounded_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_html_escape_bounded_core
// Self-checking bench for the bounded HTML escaper. Source words go in over a
// valid/ready channel with bursty gaps while the result channel stalls on its
// own pattern. A scoreboard class predicts every escaped word (entities, the
// buffer-full drop, the entity-overflow error and the terminator). It then
// compares each accepted result field by field. The capacity register is
// programmed over APB between phases, read back, and swept across its
// extremes.
// ----------------------------------------------------------------------------
module tb_html_escape_bounded_core;
    import heb_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 10;
    localparam int          DRAIN_CYCLES = 48;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RAND_PHASES  = 6;
    localparam int          PHASE_WORDS  = 21;
    localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(4 * REG_DEST_CAPACITY);

    typedef enum logic [1:0] {
        STR_ACTIVE  = 2'd0,
        STR_FAULTED = 2'd2
    } str_phase_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_MOSTLY
    } rx_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoo;
        logic       st;
    } esc_word_t;

    class escape_scoreboard;
        logic [CAP_W-1:0] capacity;
        int unsigned      position;
        str_phase_t       phase;
        esc_word_t        expected_q[$];
        int unsigned      mismatches;
        int unsigned      sources;
        int unsigned      words;
        int unsigned      strings_closed;
        int unsigned      overflows;

        function new();
            capacity       = CAP_RESET;
            position       = 0;
            phase          = STR_ACTIVE;
            mismatches     = 0;
            sources        = 0;
            words          = 0;
            strings_closed = 0;
            overflows      = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void push_word(logic [7:0] ch, logic eoo, logic st);
            esc_word_t w;
            w.ch  = ch;
            w.eoo = eoo;
            w.st  = st;
            expected_q.push_back(w);
        endfunction

        function void note_source(logic [7:0] ch);
            int unsigned limit;
            string       ent;
            sources++;
            limit = (capacity == '0) ? 1 : int'(capacity);
            if (ch == CH_NUL) begin
                if (phase != STR_FAULTED) begin
                    push_word(CH_NUL, 1'b1, 1'b0);
                end
                strings_closed++;
                position = 0;
                phase    = STR_ACTIVE;
                return;
            end
            if (phase == STR_FAULTED || position >= limit - 1) begin
                return;
            end
            case (ch)
                CH_LT:   ent = "&lt;";
                CH_GT:   ent = "&gt;";
                CH_AMP:  ent = "&amp;";
                CH_QUOT: ent = "&quot;";
                CH_APOS: ent = "&#39;";
                default: ent = "";
            endcase
            if (ent.len() == 0) begin
                push_word(ch, 1'b0, 1'b0);
                position++;
            end else if (position + ent.len() < limit) begin
                for (int i = 0; i < ent.len(); i++) begin
                    push_word(8'(ent[i]), 1'b0, 1'b0);
                end
                position += ent.len();
            end else begin
                push_word(CH_NUL, 1'b1, 1'b1);
                overflows++;
                phase = STR_FAULTED;
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_word(logic [7:0] ch, logic eoo, logic st);
            esc_word_t w;
            words++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word ch=%02h eoo=%0b st=%0b", ch, eoo, st));
                return;
            end
            w = expected_q.pop_front();
            if (ch !== w.ch) begin
                report($sformatf("out_char %02h, want %02h", ch, w.ch));
            end
            if (eoo !== w.eoo) begin
                report($sformatf("end_of_output %0b, want %0b", eoo, w.eoo));
            end
            if (st !== w.st) begin
                report($sformatf("status %0b, want %0b", st, w.st));
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_out_char;
    logic                  m_end_of_output;
    logic                  m_status;

    escape_scoreboard sb = new();
    int unsigned      cycles = 0;
    int unsigned      burst_left = 0;
    int unsigned      rx_tick = 0;
    int unsigned      cap_writes = 0;
    rx_mode_t         rx_mode = RX_OPEN;

    html_escape_bounded_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_value    (s_char_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_end_of_output (m_end_of_output),
        .m_status        (m_status)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:     m_ready = 1'b1;
            RX_COIN:     m_ready = 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready = (rx_tick % 4 == 0);
            default:     m_ready = ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_out_char, m_end_of_output, m_status);
        end
    end

    task automatic send_source(input logic [7:0] ch);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid      = 1'b1;
        s_char_value = ch;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_source(ch);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid    = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_capacity(input logic [CAP_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CAP_ADDR;
        pwdata  = {(APB_DATA_W - CAP_W)'($urandom), value};
        @(negedge aclk);
        penable = 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        sb.set_capacity(value);
        cap_writes++;
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        readback = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback[CAP_W-1:0] !== value) begin
            sb.report($sformatf("capacity readback %04h, want %04h",
                                readback[CAP_W-1:0], value));
        end
    endtask

    function automatic logic [7:0] pick_source();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return CH_NUL;
        end else if (r < 8 && sb.phase == STR_ACTIVE) begin
            return CH_NUL;
        end else if (r < 30) begin
            case ($urandom_range(0, 4))
                0:       return CH_LT;
                1:       return CH_GT;
                2:       return CH_AMP;
                3:       return CH_QUOT;
                default: return CH_APOS;
            endcase
        end
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity(input int unsigned idx);
        if (idx == 0) return 16'hFFFF;
        if (idx == 1) return 16'd1;
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 1));
            1:       return 16'($urandom_range(2, 8));
            2:       return 16'($urandom_range(9, 30));
            3:       return 16'hFFFF;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(31, 300));
        endcase
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset capacity: extreme bytes and every entity
        send_source(8'h01);
        send_source(8'hFF);
        send_source(CH_LT);
        send_source(CH_GT);
        send_source(CH_AMP);
        send_source(CH_QUOT);
        send_source(CH_APOS);
        send_source(8'h80);
        send_source(8'h7F);
        send_source(CH_NUL);
        settle();

        // zero capacity behaves as one: only the terminator comes out
        program_capacity(16'd0);
        send_source(8'h61);
        send_source(CH_NUL);
        settle();

        // entity overflow, then drop until the terminator
        program_capacity(16'd6);
        send_source(8'h61);
        send_source(8'h62);
        send_source(8'h63);
        send_source(CH_LT);
        send_source(8'h78);
        send_source(CH_NUL);
        settle();

        // buffer full: trailing bytes dropped, terminator still ok
        program_capacity(16'd4);
        send_source(8'h61);
        send_source(8'h62);
        send_source(8'h63);
        send_source(8'h64);
        send_source(CH_NUL);
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            program_capacity(pick_capacity(p));
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_source(pick_source());
            end
            settle();
        end

        $display("covered %0d source words, %0d result words, %0d strings, %0d overflows",
                 sb.sources, sb.words, sb.strings_closed, sb.overflows);
        $display("capacity programmed %0d times, extremes 0/1/65535 included", cap_writes);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/heb_pkg.sv
sv/heb_queue.sv
sv/heb_front.sv
sv/heb_back.sv
sv/html_escape_bounded_core.sv
verif/tb_html_escape_bounded_core.sv
